FILE: hdl/acr_pkg.sv
// Shared types, constants and helpers of the audio channel remapper.
package acr_pkg;

	localparam int NUM_CH    = 8;
	localparam int SAMPLE_W  = 32;
	localparam int NARROW_W  = 16;
	localparam int PAIR_W    = SAMPLE_W + 1;
	localparam int SUM_W     = SAMPLE_W + 3;
	localparam int CNT_W     = 4;
	localparam int DIV_STEPS = 7;
	localparam int DIV_ITER  = SUM_W / DIV_STEPS;
	localparam int DIV_LAT   = DIV_ITER + 2;
	localparam int PIPE      = 3 + DIV_LAT;

	localparam logic [1:0] POL_COPY    = 2'd0;
	localparam logic [1:0] POL_AVERAGE = 2'd1;
	localparam logic [1:0] POL_IGNORE  = 2'd2;

	localparam logic [2:0] REG_SRC_CODE   = 3'd0;
	localparam logic [2:0] REG_DST_CODE   = 3'd1;
	localparam logic [2:0] REG_WIDE       = 3'd2;
	localparam logic [2:0] REG_SRC_POLICY = 3'd3;
	localparam logic [2:0] REG_DST_POLICY = 3'd4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PAIR_W-1:0]   pair_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [CNT_W-1:0]           cnt_t;

	typedef struct packed {
		sum_t sum;
		cnt_t cnt;
	} avg_req_t;

	function automatic logic [1:0] policy_of(input logic [15:0] pol_reg, input int ch);
		return pol_reg[2*ch +: 2];
	endfunction

endpackage

FILE: hdl/acr_lane.sv
// One channel lane: sample width handling and the channel's participation flag.
module acr_lane import acr_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [SAMPLE_W-1:0] raw,
	input  logic                wide,
	input  logic [1:0]          policy,
	input  logic                active,
	output sample_t             sample_s1,
	output logic                used_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= wide ? sample_t'(raw)
				: sample_t'({{(SAMPLE_W-NARROW_W){raw[NARROW_W-1]}}, raw[NARROW_W-1:0]});
			used_s1 <= active && (policy != POL_IGNORE);
		end
	end

endmodule

FILE: hdl/acr_merge.sv
// Two-level registered adder tree that combines the lanes into sums and counts.
module acr_merge import acr_pkg::*; (
	input  logic              clk,
	input  logic              en_s2,
	input  logic              en_s3,
	input  sample_t           samples [NUM_CH],
	input  logic [NUM_CH-1:0] used,
	input  logic              side_sel,
	output avg_req_t          req_a_s3,
	output avg_req_t          req_b_s3
);

	sample_t masked [NUM_CH];
	pair_t   pair_s2 [NUM_CH/2];
	pair_t   side0_s2;
	pair_t   side1_s2;
	cnt_t    cnt_all_s2;
	cnt_t    cnt_side0_s2;
	cnt_t    cnt_side1_s2;
	sum_t    total;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			masked[i] = used[i] ? samples[i] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int j = 0; j < NUM_CH/2; j++) begin
				pair_s2[j] <= pair_t'(masked[2*j]) + pair_t'(masked[2*j+1]);
			end
			side0_s2     <= pair_t'(masked[0]) + pair_t'(masked[2]);
			side1_s2     <= pair_t'(masked[1]) + pair_t'(masked[3]);
			cnt_all_s2   <= cnt_t'($countones(used));
			cnt_side0_s2 <= cnt_t'(used[0]) + cnt_t'(used[2]);
			cnt_side1_s2 <= cnt_t'(used[1]) + cnt_t'(used[3]);
		end
	end

	always_comb begin
		total = '0;
		for (int j = 0; j < NUM_CH/2; j++) begin
			total = total + sum_t'(pair_s2[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			req_a_s3.sum <= side_sel ? sum_t'(side0_s2) : total;
			req_a_s3.cnt <= side_sel ? cnt_side0_s2 : cnt_all_s2;
			req_b_s3.sum <= sum_t'(side1_s2);
			req_b_s3.cnt <= cnt_side1_s2;
		end
	end

endmodule

FILE: hdl/acr_div.sv
// Pipelined signed divider of a channel sum by a small count, truncating toward zero.
module acr_div import acr_pkg::*; (
	input  logic               clk,
	input  logic [DIV_LAT-1:0] en,
	input  avg_req_t           req,
	output sample_t            avg
);

	logic [SUM_W-1:0] work_q [DIV_ITER+1];
	cnt_t             rem_q  [DIV_ITER];
	cnt_t             dsr_q  [DIV_ITER];
	logic             neg_q  [DIV_ITER+1];
	logic             zero_q [DIV_ITER+1];
	sample_t          avg_q;
	logic [SUM_W-1:0] result;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_q[0]  <= req.sum[SUM_W-1];
			zero_q[0] <= (req.cnt == '0);
			dsr_q[0]  <= req.cnt;
			rem_q[0]  <= '0;
			work_q[0] <= req.sum[SUM_W-1] ? (-req.sum) : req.sum;
		end
	end

	for (genvar k = 1; k <= DIV_ITER; k++) begin : g_iter
		logic [SUM_W-1:0] w_next;
		cnt_t             r_next;

		always_comb begin
			logic [SUM_W-1:0] w;
			cnt_t             r;
			cnt_t             t;
			w = work_q[k-1];
			r = rem_q[k-1];
			for (int i = 0; i < DIV_STEPS; i++) begin
				t = {r[CNT_W-2:0], w[SUM_W-1]};
				w = {w[SUM_W-2:0], 1'b0};
				if (t >= dsr_q[k-1]) begin
					t    = t - dsr_q[k-1];
					w[0] = 1'b1;
				end
				r = t;
			end
			w_next = w;
			r_next = r;
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				work_q[k] <= w_next;
				neg_q[k]  <= neg_q[k-1];
				zero_q[k] <= zero_q[k-1];
			end
		end

		if (k < DIV_ITER) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_q[k] <= r_next;
					dsr_q[k] <= dsr_q[k-1];
				end
			end
		end
	end

	always_comb begin
		if (zero_q[DIV_ITER]) begin
			result = '0;
		end else if (neg_q[DIV_ITER]) begin
			result = -work_q[DIV_ITER];
		end else begin
			result = work_q[DIV_ITER];
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_LAT-1]) begin
			avg_q <= sample_t'(result[SAMPLE_W-1:0]);
		end
	end

	assign avg = avg_q;

endmodule

FILE: hdl/audio_channel_remapper_core.sv
// Top level of the audio channel remapper: configuration, lanes, merge, divide and output.
//
// The input channel takes one PCM frame per word on in_valid/in_ready: eight
// sample fields and a last marker. The output channel gives one remapped frame
// per word on out_valid/out_ready, with a write mask, an unsupported-pair flag
// and the copied last marker. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the block holds no
// frame; the block itself does not enforce it. A frame is accepted on every
// cycle the pipeline can move, so throughput is one word per cycle. From the
// accepting edge to out_valid a word crosses eleven registers: one lane stage,
// two adder-tree stages, seven stages of the pipelined average divider and the
// output register, and the first of them loads at the accepting edge.
// When the receiver stalls, the output register holds its word, and stages
// behind it keep filling until every stage holds a word; in_ready then falls.
// Reset empties the pipeline and returns the registers to stereo in, stereo
// out, sixteen-bit samples and copy policies.
module audio_channel_remapper_core import acr_pkg::*; #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  sample_t     in_ch0,
	input  sample_t     in_ch1,
	input  sample_t     in_ch2,
	input  sample_t     in_ch3,
	input  sample_t     in_ch4,
	input  sample_t     in_ch5,
	input  sample_t     in_ch6,
	input  sample_t     in_ch7,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output sample_t     out_ch0,
	output sample_t     out_ch1,
	output sample_t     out_ch2,
	output sample_t     out_ch3,
	output sample_t     out_ch4,
	output sample_t     out_ch5,
	output sample_t     out_ch6,
	output sample_t     out_ch7,
	output logic [7:0]  write_mask,
	output logic        unsupported,
	output logic        out_last
);

	logic [1:0]  src_code_q;
	logic [1:0]  dst_code_q;
	logic        wide_q;
	logic [15:0] src_policy_q;
	logic [15:0] dst_policy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_code_q   <= 2'd1;
			dst_code_q   <= 2'd1;
			wide_q       <= 1'b0;
			src_policy_q <= '0;
			dst_policy_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_CODE:   src_code_q   <= cfg_data[1:0];
				REG_DST_CODE:   dst_code_q   <= cfg_data[1:0];
				REG_WIDE:       wide_q       <= cfg_data[0];
				REG_SRC_POLICY: src_policy_q <= cfg_data;
				REG_DST_POLICY: dst_policy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cnt_t ns;
	cnt_t nd;
	logic supported;
	logic mode_2to4;
	logic mode_4to2;
	logic mode_2to2;

	always_comb begin
		ns = cnt_t'(1) << src_code_q;
		nd = cnt_t'(1) << dst_code_q;
		if (ns > MAX_CHANNELS || nd > MAX_CHANNELS) begin
			supported = 1'b0;
		end else if (ns == cnt_t'(1)) begin
			supported = (nd != cnt_t'(1));
		end else if (ns == cnt_t'(2)) begin
			supported = 1'b1;
		end else begin
			supported = (nd <= cnt_t'(2));
		end
		mode_2to4 = (ns == cnt_t'(2)) && (nd == cnt_t'(4));
		mode_4to2 = (ns == cnt_t'(4)) && (nd == cnt_t'(2));
		mode_2to2 = (ns == cnt_t'(2)) && (nd == cnt_t'(2));
	end

	logic [PIPE:0]   rdy;
	logic [PIPE-1:0] valid_q;
	logic            out_valid_q;

	always_comb begin
		rdy[PIPE] = !out_valid_q || out_ready;
		for (int k = PIPE - 1; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < PIPE; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
			if (rdy[PIPE]) begin
				out_valid_q <= valid_q[PIPE-1];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = out_valid_q;

	logic [SAMPLE_W-1:0] raw [NUM_CH];
	sample_t             lane_sample [NUM_CH];
	logic [NUM_CH-1:0]   lane_used;

	assign raw[0] = in_ch0;
	assign raw[1] = in_ch1;
	assign raw[2] = in_ch2;
	assign raw[3] = in_ch3;
	assign raw[4] = in_ch4;
	assign raw[5] = in_ch5;
	assign raw[6] = in_ch6;
	assign raw[7] = in_ch7;

	for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
		acr_lane u_lane (
			.clk       (clk),
			.en        (rdy[0]),
			.raw       (raw[i]),
			.wide      (wide_q),
			.policy    (policy_of(src_policy_q, i)),
			.active    (cnt_t'(i) < ns),
			.sample_s1 (lane_sample[i]),
			.used_s1   (lane_used[i])
		);
	end

	avg_req_t req_a_s3;
	avg_req_t req_b_s3;

	acr_merge u_merge (
		.clk      (clk),
		.en_s2    (rdy[1]),
		.en_s3    (rdy[2]),
		.samples  (lane_sample),
		.used     (lane_used),
		.side_sel (mode_4to2),
		.req_a_s3 (req_a_s3),
		.req_b_s3 (req_b_s3)
	);

	sample_t avg_a;
	sample_t avg_b;

	acr_div u_div_a (
		.clk (clk),
		.en  (rdy[3 +: DIV_LAT]),
		.req (req_a_s3),
		.avg (avg_a)
	);

	acr_div u_div_b (
		.clk (clk),
		.en  (rdy[3 +: DIV_LAT]),
		.req (req_b_s3),
		.avg (avg_b)
	);

	sample_t copy0_q [1:PIPE-1];
	sample_t copy1_q [1:PIPE-1];
	logic    last_q  [PIPE];

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			last_q[0] <= in_last;
		end
		if (rdy[1]) begin
			copy0_q[1] <= lane_sample[0];
			copy1_q[1] <= lane_sample[1];
		end
		for (int k = 1; k < PIPE; k++) begin
			if (rdy[k]) begin
				last_q[k] <= last_q[k-1];
			end
		end
		for (int k = 2; k < PIPE; k++) begin
			if (rdy[k]) begin
				copy0_q[k] <= copy0_q[k-1];
				copy1_q[k] <= copy1_q[k-1];
			end
		end
	end

	sample_t    o [NUM_CH];
	logic [7:0] mask;
	sample_t    s_pair [2];

	always_comb begin
		s_pair[0] = copy0_q[PIPE-1];
		s_pair[1] = copy1_q[PIPE-1];
		for (int i = 0; i < NUM_CH; i++) begin
			o[i] = '0;
		end
		mask = '0;
		if (!supported) begin
			mask = '0;
		end else if (mode_2to4) begin
			o[0] = s_pair[0];
			o[1] = s_pair[1];
			o[2] = s_pair[0];
			o[3] = s_pair[1];
			mask = 8'h0F;
		end else if (mode_4to2) begin
			o[0] = avg_a;
			o[1] = avg_b;
			mask = 8'h03;
		end else if (mode_2to2) begin
			for (int i = 0; i < 2; i++) begin
				if (policy_of(dst_policy_q, i) == POL_IGNORE) begin
					o[i] = '0;
				end else if (policy_of(dst_policy_q, i) == POL_AVERAGE) begin
					o[i] = avg_a;
				end else if (policy_of(src_policy_q, i) != POL_IGNORE) begin
					o[i] = s_pair[i];
				end else begin
					o[i] = avg_a;
				end
			end
			mask = 8'h03;
		end else begin
			for (int i = 0; i < NUM_CH; i++) begin
				if (cnt_t'(i) < nd && policy_of(dst_policy_q, i) != POL_IGNORE) begin
					o[i]    = avg_a;
					mask[i] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[PIPE]) begin
			out_ch0     <= o[0];
			out_ch1     <= o[1];
			out_ch2     <= o[2];
			out_ch3     <= o[3];
			out_ch4     <= o[4];
			out_ch5     <= o[5];
			out_ch6     <= o[6];
			out_ch7     <= o[7];
			write_mask  <= mask;
			unsupported <= !supported;
			out_last    <= last_q[PIPE-1];
		end
	end

endmodule

FILE: bench/tb_top.sv
// Testbench of the audio channel remapper core: scoreboard, drivers, receiver and checks.
`timescale 1ns / 1ps

module tb_top import acr_pkg::*; ();

	localparam int MAX_CH         = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int TIMEOUT_CYCLES = 2000;
	localparam int DRAIN_CYCLES   = PIPE + 4;
	localparam int PHASES         = 20;
	localparam int PHASE_FRAMES   = 85;

	localparam logic [1:0] CH_MONO   = 2'd0;
	localparam logic [1:0] CH_STEREO = 2'd1;
	localparam logic [1:0] CH_QUAD   = 2'd2;
	localparam logic [1:0] CH_EIGHT  = 2'd3;

	typedef struct {
		sample_t ch [8];
		logic    last;
	} frame_in_t;

	typedef struct {
		sample_t    ch [8];
		logic [7:0] mask;
		logic       unsup;
		logic       last;
	} frame_out_t;

	class remap_scoreboard;
		logic [1:0]  src_code;
		logic [1:0]  dst_code;
		logic        wide;
		logic [15:0] src_pol;
		logic [15:0] dst_pol;
		frame_out_t  expected_frames [$];
		int          mismatch_count;

		function new();
			src_code = CH_STEREO;
			dst_code = CH_STEREO;
			wide = 1'b0;
			src_pol = 16'h0000;
			dst_pol = 16'h0000;
			mismatch_count = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_SRC_CODE:   src_code = val[1:0];
				REG_DST_CODE:   dst_code = val[1:0];
				REG_WIDE:       wide = val[0];
				REG_SRC_POLICY: src_pol = val;
				REG_DST_POLICY: dst_pol = val;
				default: ;
			endcase
		endfunction

		function longint mean_of(longint s [8], int n);
			longint sum;
			longint cnt;
			sum = 0;
			cnt = 0;
			for (int i = 0; i < n && i < 8; i++) begin
				if (src_pol[2*i +: 2] != POL_IGNORE) begin
					sum += s[i];
					cnt++;
				end
			end
			return (cnt != 0) ? sum / cnt : 0;
		endfunction

		function longint mean_side(longint s [8], int a, int b);
			longint sum;
			longint cnt;
			sum = 0;
			cnt = 0;
			if (src_pol[2*a +: 2] != POL_IGNORE) begin
				sum += s[a];
				cnt++;
			end
			if (src_pol[2*b +: 2] != POL_IGNORE) begin
				sum += s[b];
				cnt++;
			end
			return (cnt != 0) ? sum / cnt : 0;
		endfunction

		function frame_out_t predict_remap(frame_in_t f);
			frame_out_t r;
			longint     s [8];
			longint     o [8];
			int         ns;
			int         nd;
			bit         ok;
			logic [1:0] dp;
			longint     avg;
			ns = 1 << src_code;
			nd = 1 << dst_code;
			for (int i = 0; i < 8; i++) begin
				s[i] = wide ? longint'($signed(f.ch[i])) : longint'($signed(f.ch[i][15:0]));
				o[i] = 0;
			end
			r.mask = 8'h00;
			r.unsup = 1'b0;
			r.last = f.last;
			if (ns > MAX_CH || nd > MAX_CH) ok = 0;
			else if (ns == 1) ok = (nd != 1);
			else if (ns == 2) ok = 1;
			else ok = (nd <= 2);
			if (!ok) begin
				r.unsup = 1'b1;
			end else if (ns == 2 && nd == 4) begin
				o[0] = s[0];
				o[1] = s[1];
				o[2] = s[0];
				o[3] = s[1];
				r.mask = 8'h0F;
			end else if (ns == 4 && nd == 2) begin
				o[0] = mean_side(s, 0, 2);
				o[1] = mean_side(s, 1, 3);
				r.mask = 8'h03;
			end else if (ns == 2 && nd == 2) begin
				for (int i = 0; i < 2; i++) begin
					dp = dst_pol[2*i +: 2];
					if (dp == POL_IGNORE) o[i] = 0;
					else if (dp == POL_AVERAGE) o[i] = mean_of(s, ns);
					else if (src_pol[2*i +: 2] != POL_IGNORE) o[i] = s[i];
					else o[i] = mean_of(s, ns);
				end
				r.mask = 8'h03;
			end else begin
				avg = mean_of(s, ns);
				for (int i = 0; i < nd && i < 8; i++) begin
					if (dst_pol[2*i +: 2] != POL_IGNORE) begin
						o[i] = avg;
						r.mask[i] = 1'b1;
					end
				end
			end
			for (int i = 0; i < 8; i++) r.ch[i] = sample_t'(o[i]);
			return r;
		endfunction

		function void note_frame(frame_in_t f);
			expected_frames.push_back(predict_remap(f));
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function void check_frame(frame_out_t a);
			frame_out_t e;
			if (expected_frames.size() == 0) begin
				$display("%0t: output word with no expected word, mask %h", $time, a.mask);
				mismatch_count++;
				return;
			end
			e = expected_frames.pop_front();
			for (int i = 0; i < 8; i++) begin
				if (a.ch[i] !== e.ch[i]) begin
					$display("%0t: out_ch%0d expected %h actual %h", $time, i, e.ch[i], a.ch[i]);
					mismatch_count++;
				end
			end
			if (a.mask !== e.mask) begin
				$display("%0t: write_mask expected %h actual %h", $time, e.mask, a.mask);
				mismatch_count++;
			end
			if (a.unsup !== e.unsup) begin
				$display("%0t: unsupported expected %b actual %b", $time, e.unsup, a.unsup);
				mismatch_count++;
			end
			if (a.last !== e.last) begin
				$display("%0t: out_last expected %b actual %b", $time, e.last, a.last);
				mismatch_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	sample_t     in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5, in_ch6, in_ch7;
	logic        in_last;
	logic        out_valid;
	logic        out_ready;
	sample_t     out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5, out_ch6, out_ch7;
	logic [7:0]  write_mask;
	logic        unsupported;
	logic        out_last;

	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	frame_in_t  in_word;
	frame_out_t out_word;

	remap_scoreboard sb = new();

	audio_channel_remapper_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_ch0      (in_ch0),
		.in_ch1      (in_ch1),
		.in_ch2      (in_ch2),
		.in_ch3      (in_ch3),
		.in_ch4      (in_ch4),
		.in_ch5      (in_ch5),
		.in_ch6      (in_ch6),
		.in_ch7      (in_ch7),
		.in_last     (in_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_ch0     (out_ch0),
		.out_ch1     (out_ch1),
		.out_ch2     (out_ch2),
		.out_ch3     (out_ch3),
		.out_ch4     (out_ch4),
		.out_ch5     (out_ch5),
		.out_ch6     (out_ch6),
		.out_ch7     (out_ch7),
		.write_mask  (write_mask),
		.unsupported (unsupported),
		.out_last    (out_last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always_comb begin
		in_word.ch[0] = in_ch0;
		in_word.ch[1] = in_ch1;
		in_word.ch[2] = in_ch2;
		in_word.ch[3] = in_ch3;
		in_word.ch[4] = in_ch4;
		in_word.ch[5] = in_ch5;
		in_word.ch[6] = in_ch6;
		in_word.ch[7] = in_ch7;
		in_word.last = in_last;
		out_word.ch[0] = out_ch0;
		out_word.ch[1] = out_ch1;
		out_word.ch[2] = out_ch2;
		out_word.ch[3] = out_ch3;
		out_word.ch[4] = out_ch4;
		out_word.ch[5] = out_ch5;
		out_word.ch[6] = out_ch6;
		out_word.ch[7] = out_ch7;
		out_word.mask = write_mask;
		out_word.unsup = unsupported;
		out_word.last = out_last;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_frame(in_word);
			if (out_valid && out_ready) sb.check_frame(out_word);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= TIMEOUT_CYCLES) begin
				$display("** audio_channel_remapper_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic sample_t random_sample();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return {16'($urandom), 16'h7FFF};
			3: return {16'($urandom), 16'h8000};
			4: return sample_t'(int'($urandom_range(0, 16)) - 8);
			default: return $urandom;
		endcase
	endfunction

	function automatic frame_in_t random_frame();
		frame_in_t f;
		for (int i = 0; i < 8; i++) f.ch[i] = random_sample();
		f.last = 1'($urandom_range(0, 1));
		return f;
	endfunction

	function automatic frame_in_t flat_frame(sample_t v, logic last);
		frame_in_t f;
		for (int i = 0; i < 8; i++) f.ch[i] = v;
		f.last = last;
		return f;
	endfunction

	function automatic logic [15:0] random_policy();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hAAAA;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic [1:0] src, input logic [1:0] dst, input logic wide,
			input logic [15:0] spol, input logic [15:0] dpol);
		write_reg(REG_SRC_CODE, {14'd0, src});
		write_reg(REG_DST_CODE, {14'd0, dst});
		write_reg(REG_WIDE, {15'd0, wide});
		write_reg(REG_SRC_POLICY, spol);
		write_reg(REG_DST_POLICY, dpol);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input frame_in_t f);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_ch0 <= f.ch[0];
		in_ch1 <= f.ch[1];
		in_ch2 <= f.ch[2];
		in_ch3 <= f.ch[3];
		in_ch4 <= f.ch[4];
		in_ch5 <= f.ch[5];
		in_ch6 <= f.ch[6];
		in_ch7 <= f.ch[7];
		in_last <= f.last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		frame_in_t f;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_ch0 = '0;
		in_ch1 = '0;
		in_ch2 = '0;
		in_ch3 = '0;
		in_ch4 = '0;
		in_ch5 = '0;
		in_ch6 = '0;
		in_ch7 = '0;
		in_last = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// Reset settings: stereo to stereo, sixteen-bit samples, copy policies.
		f = random_frame();
		f.ch[0] = 32'h1234_7FFF;
		f.ch[1] = 32'hABCD_8000;
		f.last = 1'b1;
		send_frame(f);
		send_frame(flat_frame(32'hFFFF_FFFF, 1'b0));
		send_frame(flat_frame(32'h0000_0000, 1'b1));
		f = flat_frame(32'h8000_7FFF, 1'b0);
		f.ch[1] = 32'h7FFF_8000;
		send_frame(f);
		drain();

		configure(CH_STEREO, CH_QUAD, 1'b1, 16'hAAAA, 16'hAAAA);
		f = flat_frame(32'h7FFF_FFFF, 1'b0);
		f.ch[1] = 32'h8000_0000;
		send_frame(f);
		f = flat_frame(32'h8000_0000, 1'b1);
		f.ch[1] = 32'h7FFF_FFFF;
		send_frame(f);
		drain();

		configure(CH_QUAD, CH_STEREO, 1'b1, 16'h0020, 16'hAAAA);
		f = flat_frame(32'h0000_0000, 1'b0);
		f.ch[0] = 32'h7FFF_FFFF;
		f.ch[2] = 32'h8000_0000;
		f.ch[1] = -32'sd3;
		send_frame(f);
		send_frame(flat_frame(32'h8000_0000, 1'b1));
		drain();
		configure(CH_QUAD, CH_STEREO, 1'b1, 16'h00AA, 16'h0000);
		send_frame(flat_frame(32'h7FFF_FFFF, 1'b0));
		drain();

		configure(CH_EIGHT, CH_MONO, 1'b1, 16'hFFFF, 16'h0000);
		send_frame(flat_frame(32'h7FFF_FFFF, 1'b0));
		send_frame(flat_frame(32'h8000_0000, 1'b1));
		f = flat_frame(32'h0000_0000, 1'b0);
		f.ch[0] = -32'sd9;
		f.ch[7] = 32'sd2;
		send_frame(f);
		drain();

		configure(CH_STEREO, CH_STEREO, 1'b1, 16'h0002, 16'h0000);
		f = random_frame();
		send_frame(f);
		drain();
		configure(CH_STEREO, CH_STEREO, 1'b1, 16'h0000, 16'h0006);
		send_frame(random_frame());
		drain();

		configure(CH_MONO, CH_MONO, 1'b0, 16'h0000, 16'h0000);
		send_frame(random_frame());
		drain();
		configure(CH_QUAD, CH_QUAD, 1'b0, 16'h0000, 16'h0000);
		send_frame(random_frame());
		drain();
		configure(CH_EIGHT, CH_EIGHT, 1'b0, 16'hFFFF, 16'hFFFF);
		send_frame(random_frame());
		drain();

		configure(CH_MONO, CH_EIGHT, 1'b0, 16'h0000, 16'h8888);
		send_frame(flat_frame(32'h0000_8000, 1'b1));
		send_frame(random_frame());
		drain();

		for (int p = 0; p < PHASES; p++) begin
			configure(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), random_policy(), random_policy());
			if (p >= PHASES - 3) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			if (p == 4) hold_req = 1'b1;
			for (int k = 0; k < PHASE_FRAMES; k++) send_frame(random_frame());
			drain();
		end

		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("** audio_channel_remapper_core: PASSED **");
		end else begin
			$display("** audio_channel_remapper_core: FAILED **");
		end
		$finish;
	end

endmodule
